>>> rtl/core/wms_pkg.sv
// ----------------------------------------------------------------------------
// wms_pkg
// Shared types, register map, mode codes and timing helpers for the wiper
// motor sequencer.
// ----------------------------------------------------------------------------
package wms_pkg;

  localparam int DUTY_W    = 6;
  localparam int TIMER_W   = 16;
  localparam int TICK_W    = 8;
  localparam int HALF_W    = 12;
  localparam int PAUSE_W   = 14;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 14;

  localparam logic [DUTY_W-1:0]  DUTY_STEPS = 6'd50;
  localparam logic [TIMER_W-1:0] TIMER_MAX  = 16'hFFFF;

  localparam logic [2:0] SWEEP_WAIT = 3'd7;

  localparam logic [1:0] MODE_HIGH  = 2'd0;
  localparam logic [1:0] MODE_LOW   = 2'd1;
  localparam logic [1:0] MODE_INTER = 2'd2;
  localparam logic [1:0] MODE_OFF   = 2'd3;

  localparam logic [1:0] IVAL_SHORT  = 2'd0;
  localparam logic [1:0] IVAL_MEDIUM = 2'd1;

  localparam logic [CFG_IDX_W-1:0] REG_TICK_MS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_HALF   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_HALF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE_SHORT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE_MED   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE_LONG  = 3'd6;

  localparam logic [TICK_W-1:0]  RST_TICK_MS     = 8'd10;
  localparam logic [HALF_W-1:0]  RST_FAST_HALF   = 12'd140;
  localparam logic [HALF_W-1:0]  RST_SLOW_HALF   = 12'd280;
  localparam logic [HALF_W-1:0]  RST_RAMP_STEP   = 12'd5;
  localparam logic [PAUSE_W-1:0] RST_PAUSE_SHORT = 14'd300;
  localparam logic [PAUSE_W-1:0] RST_PAUSE_MED   = 14'd600;
  localparam logic [PAUSE_W-1:0] RST_PAUSE_LONG  = 14'd800;

  typedef struct packed {
    logic [TICK_W-1:0]  tick_ms;
    logic [HALF_W-1:0]  fast_half_ms;
    logic [HALF_W-1:0]  slow_half_ms;
    logic [HALF_W-1:0]  ramp_step_ms;
    logic [PAUSE_W-1:0] pause_short_ms;
    logic [PAUSE_W-1:0] pause_medium_ms;
    logic [PAUSE_W-1:0] pause_long_ms;
  } cfg_t;

  function automatic logic [TIMER_W-1:0] sat_add(input logic [TIMER_W-1:0] a,
                                                 input logic [TICK_W-1:0]  b);
    logic [TIMER_W:0] s;
    s = {1'b0, a} + {{(TIMER_W-TICK_W+1){1'b0}}, b};
    return s[TIMER_W] ? TIMER_MAX : s[TIMER_W-1:0];
  endfunction

endpackage

>>> rtl/core/wms_seq.sv
// ----------------------------------------------------------------------------
// wms_seq
// Eight-state sweep sequencer: timers, duty ramp and registered result.
// ----------------------------------------------------------------------------
module wms_seq
  import wms_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              engine_on,
  input  logic [1:0]        mode_select,
  input  logic [1:0]        interval_select,
  input  cfg_t              cfg,
  output logic [DUTY_W-1:0] duty_step,
  output logic [2:0]        sweep_phase
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_HI1  = 3'd1,
    PH_HI2  = 3'd2,
    PH_LO1  = 3'd3,
    PH_LO2  = 3'd4,
    PH_INT1 = 3'd5,
    PH_INT2 = 3'd6,
    PH_WAIT = SWEEP_WAIT
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [TIMER_W-1:0]  elapsed_r, elapsed_nxt;
  logic [TIMER_W-1:0]  ramp_r, ramp_nxt;
  logic [DUTY_W-1:0]   duty_r, duty_nxt;
  logic [DUTY_W-1:0]   drive;
  logic [DUTY_W-1:0]   duty_step_r;
  logic [2:0]          sweep_phase_r;
  logic                adv_el, adv_ramp;
  logic [PAUSE_W-1:0]  pause;
  logic [TIMER_W-1:0]  fast_full, slow_full, fast_half, slow_half, ramp_step;
  logic                ramp_hit;

  assign fast_half = {{(TIMER_W-HALF_W){1'b0}}, cfg.fast_half_ms};
  assign slow_half = {{(TIMER_W-HALF_W){1'b0}}, cfg.slow_half_ms};
  assign ramp_step = {{(TIMER_W-HALF_W){1'b0}}, cfg.ramp_step_ms};
  assign fast_full = {{(TIMER_W-HALF_W-1){1'b0}}, cfg.fast_half_ms, 1'b0};
  assign slow_full = {{(TIMER_W-HALF_W-1){1'b0}}, cfg.slow_half_ms, 1'b0};
  assign ramp_hit  = ramp_r >= ramp_step;

  always_comb begin
    priority if (interval_select == IVAL_SHORT) begin
      pause = cfg.pause_short_ms;
    end else if (interval_select == IVAL_MEDIUM) begin
      pause = cfg.pause_medium_ms;
    end else begin
      pause = cfg.pause_long_ms;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    ramp_nxt    = ramp_r;
    duty_nxt    = duty_r;
    drive       = duty_r;
    adv_el      = 1'b1;
    adv_ramp    = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        elapsed_nxt = '0;
        ramp_nxt    = '0;
        duty_nxt    = '0;
        adv_el      = 1'b0;
        priority if (!engine_on || mode_select == MODE_OFF) begin
          phase_nxt = PH_IDLE;
        end else if (mode_select == MODE_HIGH) begin
          phase_nxt = PH_HI1;
        end else if (mode_select == MODE_LOW) begin
          phase_nxt = PH_LO1;
        end else begin
          phase_nxt = PH_INT1;
        end
        drive = '0;
      end
      PH_HI1: begin
        if (elapsed_r >= fast_half) begin
          phase_nxt = PH_HI2;
        end
        drive = '0;
      end
      PH_HI2: begin
        if (elapsed_r >= fast_full) begin
          if (engine_on && mode_select == MODE_HIGH) begin
            elapsed_nxt = '0;
            phase_nxt   = PH_HI1;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        drive = DUTY_STEPS;
      end
      PH_LO1, PH_INT1: begin
        adv_ramp = 1'b1;
        if (elapsed_r >= slow_half) begin
          duty_nxt  = DUTY_STEPS;
          phase_nxt = (phase_r == PH_LO1) ? PH_LO2 : PH_INT2;
        end else if (ramp_hit) begin
          ramp_nxt = '0;
          if (duty_r < DUTY_STEPS) begin
            duty_nxt = duty_r + 1'b1;
          end
        end
        drive = duty_nxt;
      end
      PH_LO2, PH_INT2: begin
        adv_ramp = 1'b1;
        if (elapsed_r >= slow_full) begin
          elapsed_nxt = '0;
          duty_nxt    = '0;
          phase_nxt   = (phase_r == PH_LO2) ? PH_IDLE : PH_WAIT;
        end else if (ramp_hit) begin
          ramp_nxt = '0;
          if (duty_r != '0) begin
            duty_nxt = duty_r - 1'b1;
          end
        end
        drive = duty_nxt;
      end
      PH_WAIT: begin
        if (!engine_on || mode_select != MODE_INTER) begin
          phase_nxt = PH_IDLE;
        end
        if (elapsed_r >= {{(TIMER_W-PAUSE_W){1'b0}}, pause}) begin
          elapsed_nxt = '0;
          phase_nxt   = PH_INT1;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
    if (adv_el) begin
      elapsed_nxt = sat_add(elapsed_nxt, cfg.tick_ms);
    end
    if (adv_ramp) begin
      ramp_nxt = sat_add(ramp_nxt, cfg.tick_ms);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      elapsed_r <= '0;
      ramp_r    <= '0;
      duty_r    <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      ramp_r    <= ramp_nxt;
      duty_r    <= duty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      duty_step_r   <= drive;
      sweep_phase_r <= phase_nxt;
    end
  end

  assign duty_step   = duty_step_r;
  assign sweep_phase = sweep_phase_r;

endmodule

>>> rtl/core/wiper_motor_sequencer.sv
// ----------------------------------------------------------------------------
// wiper_motor_sequencer
// Wiper servo sweep sequencer: one duty index and phase per timer tick.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   engine_on, mode_select,
//                                             interval_select
//   out_     output     out_valid / out_ready duty_step, sweep_phase
//   cfg_     input      cfg_valid / cfg_ready index, data (7 registers)
//
// One item per cycle while in_ready is high; the result appears in the cycle after acceptance.
// The sequencer state and the result register update in the same cycle.
// A new item is taken while a held result is being drained (in_ready is
// low only when the result register is full and out_ready is low).
// Reset is synchronous, clears the sequencer to idle, registers to defaults.
// ----------------------------------------------------------------------------
module wiper_motor_sequencer
  import wms_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_engine_on,
  input  logic [1:0]           in_mode_select,
  input  logic [1:0]           in_interval_select,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DUTY_W-1:0]    out_duty_step,
  output logic [2:0]           out_sweep_phase,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  cfg_t cfg_r;
  logic out_valid_r;
  logic step;

  assign in_ready  = !out_valid_r || out_ready;
  assign step      = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tick_ms         <= RST_TICK_MS;
      cfg_r.fast_half_ms    <= RST_FAST_HALF;
      cfg_r.slow_half_ms    <= RST_SLOW_HALF;
      cfg_r.ramp_step_ms    <= RST_RAMP_STEP;
      cfg_r.pause_short_ms  <= RST_PAUSE_SHORT;
      cfg_r.pause_medium_ms <= RST_PAUSE_MED;
      cfg_r.pause_long_ms   <= RST_PAUSE_LONG;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TICK_MS:     cfg_r.tick_ms         <= cfg_data[TICK_W-1:0];
        REG_FAST_HALF:   cfg_r.fast_half_ms    <= cfg_data[HALF_W-1:0];
        REG_SLOW_HALF:   cfg_r.slow_half_ms    <= cfg_data[HALF_W-1:0];
        REG_RAMP_STEP:   cfg_r.ramp_step_ms    <= cfg_data[HALF_W-1:0];
        REG_PAUSE_SHORT: cfg_r.pause_short_ms  <= cfg_data[PAUSE_W-1:0];
        REG_PAUSE_MED:   cfg_r.pause_medium_ms <= cfg_data[PAUSE_W-1:0];
        REG_PAUSE_LONG:  cfg_r.pause_long_ms   <= cfg_data[PAUSE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  wms_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (step),
    .engine_on       (in_engine_on),
    .mode_select     (in_mode_select),
    .interval_select (in_interval_select),
    .cfg             (cfg_r),
    .duty_step       (out_duty_step),
    .sweep_phase     (out_sweep_phase)
  );

endmodule

>>> rtl/core/wms_checker.sv
// ----------------------------------------------------------------------------
// wms_checker
// Port-level checks for the wiper motor sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module wms_checker
  import wms_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DUTY_W-1:0] out_duty_step,
  input logic [2:0]        out_sweep_phase
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_duty_step)
      && $stable(out_sweep_phase))
    else $error("stalled result changed");

  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_duty_step <= DUTY_STEPS)
    else $error("duty index above maximum");

  a_wait_min_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sweep_phase == SWEEP_WAIT |-> out_duty_step == '0)
    else $error("pause phase drives nonzero duty");

endmodule

bind wiper_motor_sequencer wms_checker u_wms_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_duty_step   (out_duty_step),
  .out_sweep_phase (out_sweep_phase)
);

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: wiper_motor_sequencer testbench
// Drives timer ticks with random gaps and result stalls. A local copy of the
// sweep sequencer predicts the duty index and phase of every tick, and each
// result is checked against it in order. The sequence of tests is: default
// registers, directed corner ticks, a long result hold-off, then minimum,
// maximum, duty-clamp and random register settings.
// ----------------------------------------------------------------------------
module tb_top;
  import wms_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]           IVAL_LONG   = 2'd2;
  localparam logic [1:0]           IVAL_CODE3  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 3'd7;
  localparam int                   QUIET_LIMIT = 2000;
  localparam int                   HOLD_CYCLES = 300;

  typedef enum logic [2:0] {
    ST_IDLE, ST_HI1, ST_HI2, ST_LO1, ST_LO2, ST_INT1, ST_INT2, ST_WAIT
  } sweep_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    sweep_t            phase;
  } sweep_result_t;

  logic                 clk;
  logic                 rst_n              = 1'b0;
  logic                 in_valid           = 1'b0;
  logic                 in_ready;
  logic                 in_engine_on       = 1'b0;
  logic [1:0]           in_mode_select     = MODE_OFF;
  logic [1:0]           in_interval_select = IVAL_SHORT;
  logic                 out_valid;
  logic                 out_ready          = 1'b0;
  logic [DUTY_W-1:0]    out_duty_step;
  logic [2:0]           out_sweep_phase;
  logic                 cfg_valid          = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index          = '0;
  logic [CFG_DAT_W-1:0] cfg_data           = '0;

  cfg_t               regs;
  sweep_t             sw_phase;
  logic [TIMER_W-1:0] elapsed_ms;
  logic [TIMER_W-1:0] ramp_ms;
  logic [DUTY_W-1:0]  duty_idx;
  sweep_result_t      result_q[$];

  int  fails        = 0;
  int  checked      = 0;
  int  ticks_sent   = 0;
  int  settings_cnt = 0;
  int  quiet        = 0;
  int  hold_len     = 0;
  bit  tx_gaps_on   = 1'b1;
  bit  rx_stalls_on = 1'b1;

  wiper_motor_sequencer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_engine_on       (in_engine_on),
    .in_mode_select     (in_mode_select),
    .in_interval_select (in_interval_select),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_duty_step      (out_duty_step),
    .out_sweep_phase    (out_sweep_phase),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void reset_prediction();
    regs.tick_ms         = RST_TICK_MS;
    regs.fast_half_ms    = RST_FAST_HALF;
    regs.slow_half_ms    = RST_SLOW_HALF;
    regs.ramp_step_ms    = RST_RAMP_STEP;
    regs.pause_short_ms  = RST_PAUSE_SHORT;
    regs.pause_medium_ms = RST_PAUSE_MED;
    regs.pause_long_ms   = RST_PAUSE_LONG;
    sw_phase   = ST_IDLE;
    elapsed_ms = '0;
    ramp_ms    = '0;
    duty_idx   = '0;
  endfunction

  function automatic void store_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DAT_W-1:0] d);
    case (idx)
      REG_TICK_MS:     regs.tick_ms         = d[TICK_W-1:0];
      REG_FAST_HALF:   regs.fast_half_ms    = d[HALF_W-1:0];
      REG_SLOW_HALF:   regs.slow_half_ms    = d[HALF_W-1:0];
      REG_RAMP_STEP:   regs.ramp_step_ms    = d[HALF_W-1:0];
      REG_PAUSE_SHORT: regs.pause_short_ms  = d[PAUSE_W-1:0];
      REG_PAUSE_MED:   regs.pause_medium_ms = d[PAUSE_W-1:0];
      REG_PAUSE_LONG:  regs.pause_long_ms   = d[PAUSE_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [TIMER_W-1:0] bump(input logic [TIMER_W-1:0] t);
    int s;
    s = int'(t) + int'(regs.tick_ms);
    return (s > int'(TIMER_MAX)) ? TIMER_MAX : s[TIMER_W-1:0];
  endfunction

  function automatic bit ramp_rise();
    if (int'(elapsed_ms) >= int'(regs.slow_half_ms)) begin
      duty_idx = DUTY_STEPS;
      return 1'b1;
    end
    if (int'(ramp_ms) >= int'(regs.ramp_step_ms)) begin
      ramp_ms = '0;
      if (duty_idx < DUTY_STEPS) duty_idx = duty_idx + 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit ramp_fall();
    if (int'(elapsed_ms) >= 2 * int'(regs.slow_half_ms)) begin
      elapsed_ms = '0;
      duty_idx   = '0;
      return 1'b1;
    end
    if (int'(ramp_ms) >= int'(regs.ramp_step_ms)) begin
      ramp_ms = '0;
      if (duty_idx > 0) duty_idx = duty_idx - 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void predict_sweep_tick(input logic eng, input logic [1:0] mode,
                                             input logic [1:0] ival);
    logic [DUTY_W-1:0]  drive;
    logic [PAUSE_W-1:0] pause_ms;
    sweep_result_t      res;
    drive = '0;
    case (sw_phase)
      ST_IDLE: begin
        elapsed_ms = '0;
        ramp_ms    = '0;
        duty_idx   = '0;
        if (!eng || mode == MODE_OFF) sw_phase = ST_IDLE;
        else if (mode == MODE_HIGH) sw_phase = ST_HI1;
        else if (mode == MODE_LOW) sw_phase = ST_LO1;
        else sw_phase = ST_INT1;
      end
      ST_HI1: begin
        if (int'(elapsed_ms) >= int'(regs.fast_half_ms)) sw_phase = ST_HI2;
        elapsed_ms = bump(elapsed_ms);
      end
      ST_HI2: begin
        if (int'(elapsed_ms) >= 2 * int'(regs.fast_half_ms)) begin
          if (eng && mode == MODE_HIGH) begin
            elapsed_ms = '0;
            sw_phase   = ST_HI1;
          end else begin
            sw_phase = ST_IDLE;
          end
        end
        elapsed_ms = bump(elapsed_ms);
        drive      = DUTY_STEPS;
      end
      ST_LO1, ST_INT1: begin
        if (ramp_rise()) sw_phase = (sw_phase == ST_LO1) ? ST_LO2 : ST_INT2;
        elapsed_ms = bump(elapsed_ms);
        ramp_ms    = bump(ramp_ms);
        drive      = duty_idx;
      end
      ST_LO2, ST_INT2: begin
        if (ramp_fall()) sw_phase = (sw_phase == ST_LO2) ? ST_IDLE : ST_WAIT;
        elapsed_ms = bump(elapsed_ms);
        ramp_ms    = bump(ramp_ms);
        drive      = duty_idx;
      end
      default: begin
        if (!eng || mode != MODE_INTER) sw_phase = ST_IDLE;
        if (ival == IVAL_SHORT) pause_ms = regs.pause_short_ms;
        else if (ival == IVAL_MEDIUM) pause_ms = regs.pause_medium_ms;
        else pause_ms = regs.pause_long_ms;
        if (int'(elapsed_ms) >= int'(pause_ms)) begin
          elapsed_ms = '0;
          sw_phase   = ST_INT1;
        end
        elapsed_ms = bump(elapsed_ms);
        drive      = duty_idx;
      end
    endcase
    res.duty  = drive;
    res.phase = sw_phase;
    result_q.push_back(res);
  endfunction

  always @(posedge clk) begin
    sweep_result_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) store_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        predict_sweep_tick(in_engine_on, in_mode_select, in_interval_select);
      end
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("unexpected result: duty_step %0d sweep_phase %0d",
                 out_duty_step, out_sweep_phase);
          fails++;
        end else begin
          want = result_q.pop_front();
          if (out_duty_step !== want.duty) begin
            $error("duty_step expected %0d actual %0d", want.duty, out_duty_step);
            fails++;
          end
          if (out_sweep_phase !== want.phase) begin
            $error("sweep_phase expected %0d actual %0d", want.phase, out_sweep_phase);
            fails++;
          end
          checked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet = quiet + 1;
    end
    if (quiet == QUIET_LIMIT) begin
      $display("tb_top: no handshake for %0d cycles", QUIET_LIMIT);
      $display("wiper_motor_sequencer verification failed");
      $finish;
    end
  end

  initial begin
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = rx_stalls_on ? $urandom_range(0, 11) : 0;
      if (hold_len != 0) begin
        stall    = hold_len;
        hold_len = 0;
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_tick(input logic eng, input logic [1:0] mode, input logic [1:0] ival);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_engine_on       <= eng;
    in_mode_select     <= mode;
    in_interval_select <= ival;
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
  endtask

  task automatic settle_pipeline();
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_settings(input cfg_t s);
    write_reg(REG_TICK_MS, CFG_DAT_W'(s.tick_ms));
    write_reg(REG_FAST_HALF, CFG_DAT_W'(s.fast_half_ms));
    write_reg(REG_SLOW_HALF, CFG_DAT_W'(s.slow_half_ms));
    write_reg(REG_RAMP_STEP, CFG_DAT_W'(s.ramp_step_ms));
    write_reg(REG_PAUSE_SHORT, s.pause_short_ms);
    write_reg(REG_PAUSE_MED, s.pause_medium_ms);
    write_reg(REG_PAUSE_LONG, s.pause_long_ms);
    cfg_valid <= 1'b0;
    settings_cnt++;
  endtask

  // hold a mode for a stretch so sweeps complete, with stray ticks mixed in
  task automatic run_sweep_segments(input int n_ticks);
    int         left;
    int         seg_len;
    logic       eng;
    logic [1:0] mode;
    logic [1:0] ival;
    left = n_ticks;
    while (left > 0) begin
      eng          = ($urandom_range(0, 9) != 0);
      mode         = 2'($urandom_range(0, 3));
      ival         = 2'($urandom_range(0, 3));
      seg_len      = $urandom_range(4, 120);
      tx_gaps_on   = ($urandom_range(0, 3) != 0);
      rx_stalls_on = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < seg_len && left > 0; k++) begin
        if ($urandom_range(0, 11) == 0) begin
          send_tick(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                    2'($urandom_range(0, 3)));
        end else begin
          send_tick(eng, mode, ival);
        end
        left--;
      end
    end
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    settle_pipeline();
  endtask

  task automatic test_default_settings();
    settings_cnt++;
    run_sweep_segments(315);
  endtask

  task automatic test_directed_corners();
    write_reg(REG_UNUSED, 14'h3FFF);
    write_reg(REG_TICK_MS, 14'h3F64);
    write_reg(REG_FAST_HALF, 14'd100);
    write_reg(REG_SLOW_HALF, 14'd200);
    write_reg(REG_RAMP_STEP, 14'd100);
    write_reg(REG_PAUSE_SHORT, 14'd100);
    write_reg(REG_PAUSE_MED, 14'd200);
    write_reg(REG_PAUSE_LONG, 14'd300);
    cfg_valid <= 1'b0;
    settings_cnt++;
    send_tick(1'b0, MODE_HIGH, IVAL_SHORT);
    send_tick(1'b1, MODE_OFF, IVAL_CODE3);
    repeat (5) send_tick(1'b1, MODE_HIGH, IVAL_MEDIUM);
    send_tick(1'b1, MODE_LOW, IVAL_LONG);
    repeat (6) send_tick(1'b1, MODE_LOW, IVAL_SHORT);
    repeat (8) send_tick(1'b1, MODE_INTER, IVAL_CODE3);
    send_tick(1'b0, MODE_INTER, IVAL_CODE3);
    repeat (3) send_tick(1'b1, MODE_INTER, IVAL_SHORT);
    settle_pipeline();
  endtask

  task automatic test_backpressure_fill();
    tx_gaps_on = 1'b0;
    hold_len   = HOLD_CYCLES;
    repeat (40) send_tick(1'b1, MODE_HIGH, IVAL_SHORT);
    tx_gaps_on = 1'b1;
    settle_pipeline();
  endtask

  task automatic test_minimum_settings();
    cfg_t s;
    s = '{8'd1, 12'd0, 12'd0, 12'd0, 14'd0, 14'd0, 14'd0};
    apply_settings(s);
    run_sweep_segments(315);
  endtask

  task automatic test_maximum_settings();
    cfg_t s;
    s = '{8'd255, 12'd4095, 12'd4095, 12'd4095, 14'd16383, 14'd16383, 14'd16383};
    apply_settings(s);
    run_sweep_segments(315);
  endtask

  task automatic test_duty_clamp_settings();
    cfg_t s;
    s = '{8'd1, 12'd20, 12'd80, 12'd0, 14'd10, 14'd30, 14'd60};
    apply_settings(s);
    run_sweep_segments(315);
  endtask

  task automatic test_random_settings();
    cfg_t s;
    s.tick_ms         = TICK_W'($urandom_range(1, 255));
    s.fast_half_ms    = HALF_W'($urandom_range(0, 4095));
    s.slow_half_ms    = HALF_W'($urandom_range(0, 4095));
    s.ramp_step_ms    = HALF_W'($urandom_range(0, 4095));
    s.pause_short_ms  = PAUSE_W'($urandom_range(0, 16383));
    s.pause_medium_ms = PAUSE_W'($urandom_range(0, 16383));
    s.pause_long_ms   = PAUSE_W'($urandom_range(0, 16383));
    apply_settings(s);
    run_sweep_segments(315);
  endtask

  initial begin
    reset_prediction();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_settings();
    test_directed_corners();
    test_backpressure_fill();
    test_minimum_settings();
    test_maximum_settings();
    test_duty_clamp_settings();
    test_random_settings();
    test_random_settings();
    repeat (5) @(posedge clk);
    $display("tb_top: %0d ticks sent, %0d results checked, %0d mismatches",
             ticks_sent, checked, fails);
    $display("tb_top: %0d register settings incl. min/max, one %0d-cycle output hold",
             settings_cnt, HOLD_CYCLES);
    if (fails == 0) begin
      $display("wiper_motor_sequencer verification clean");
    end else begin
      $display("wiper_motor_sequencer verification failed");
    end
    $finish;
  end

endmodule
